FILE: rtl/audio_companding_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio companding encoder
// Concurrent checks sampled on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AUDIO_COMPANDING_ENCODER_CORE_MACROS_SVH
`define AUDIO_COMPANDING_ENCODER_CORE_MACROS_SVH

// Same-cycle implication.
`define ACE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ace_pkg.sv
// ----------------------------------------------------------------------------
// ace_pkg
// Types, constants and helpers of the audio companding encoder.
// ----------------------------------------------------------------------------
package ace_pkg;

  typedef enum logic [1:0] {
    MODE_CURVE4 = 2'd0,
    MODE_CURVE8 = 2'd1,
    MODE_ALAW   = 2'd2,
    MODE_MULAW  = 2'd3
  } curve_mode_e;

  localparam logic [14:0] CURVE_KNEE    = 15'd24576;
  localparam logic [13:0] SEG_LEN4      = 14'd8192;
  localparam logic [13:0] SEG_LEN8      = 14'd4096;
  localparam logic [11:0] ALAW_LIMIT    = 12'hFFF;
  localparam logic [12:0] MULAW_LIMIT   = 13'h1FFF;
  localparam logic [16:0] MULAW_OFFSET  = 17'd33;
  localparam logic [7:0]  ALAW_XOR      = 8'h55;
  localparam logic [3:0]  LAW_MIN_POS   = 4'd4;

  // Stage B: magnitude and segment.
  typedef struct packed {
    curve_mode_e mode;
    logic        sgn;   // result negative
    logic [14:0] op;    // curve magnitude, or law value (13 bits)
    logic [3:0]  seg;   // curve segment, or law top-bit position
  } ace_seg_t;

  // Stage C: unsigned curve value or raw law code.
  typedef struct packed {
    curve_mode_e mode;
    logic        sgn;
    logic [14:0] val;
  } ace_val_t;

  // Start value of curve segment k (k >= 1); each segment adds half the last.
  function automatic logic [14:0] curve_base(input logic eight, input logic [2:0] k);
    logic [13:0] len;
    logic [14:0] base;
    len  = eight ? SEG_LEN8 : SEG_LEN4;
    base = CURVE_KNEE;
    for (int j = 1; j < 7; j++) begin
      if (3'(j) < k) begin
        base = base + 15'(len >> j);
      end
    end
    return base;
  endfunction

endpackage

FILE: rtl/audio_companding_encoder_core.sv
// ----------------------------------------------------------------------------
// audio_companding_encoder_core
// Streams signed 16-bit samples through a four-stage companding pipeline.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Signals                                 | Payload
// ---------+-----+-----------------------------------------+------------------------
// s_axis   | in  | s_axis_tvalid/tready/tdata[15:0]        | sample (signed)
// m_axis   | out | m_axis_tvalid/tready/tdata[15:0]        | coded (signed)
// cfg      | in  | cfg_valid_i/cfg_ready_o/cfg_data_i[1:0] | curve_mode
//
// One sample per cycle sustained while m_axis_tready stays high. Four
// register stages (A, B, C, D): each sample passes through them in that
// order, and its result shows on m_axis from stage D.
// Every stage has its own valid bit and takes new data when empty or when
// the stage after it moves, so bubbles close up while the output stalls.
// s_axis_tready drops only when all four stages hold data.
// Reset clears the valid bits and sets curve_mode to the eight-segment curve.
// cfg is always ready; write it only with the pipeline empty.
//
`include "audio_companding_encoder_core_macros.svh"

module audio_companding_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] coded
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);
  import ace_pkg::*;

  curve_mode_e mode_q;

  logic        valid_a_q, valid_b_q, valid_c_q, valid_d_q;
  logic        ready_a, ready_b, ready_c, ready_d;

  logic [15:0] sample_a_q;
  curve_mode_e mode_a_q;
  ace_seg_t    seg_d, seg_q;
  ace_val_t    val_d, val_q;
  logic [15:0] coded_d, coded_q;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CURVE8;
    end else if (cfg_valid_i) begin
      mode_q <= curve_mode_e'(cfg_data_i);
    end
  end

  // Per-stage ready: a stage loads when empty or when its contents move on.
  assign ready_d       = !valid_d_q || m_axis_tready;
  assign ready_c       = !valid_c_q || ready_d;
  assign ready_b       = !valid_b_q || ready_c;
  assign ready_a       = !valid_a_q || ready_b;
  assign s_axis_tready = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      if (ready_a) valid_a_q <= s_axis_tvalid;
      if (ready_b) valid_b_q <= valid_a_q;
      if (ready_c) valid_c_q <= valid_b_q;
      if (ready_d) valid_d_q <= valid_c_q;
    end
  end

  // Stage A: capture sample and mode
  always_ff @(posedge clk_i) begin
    if (ready_a) begin
      sample_a_q <= s_axis_tdata;
      mode_a_q   <= mode_q;
    end
  end

  // Stage B: magnitude, law saturation, segment / top-bit search
  logic        neg_b;
  logic [15:0] mag_b;    // 0..32768
  logic [15:0] even_b;   // magnitude with bit 0 cleared (law modes)
  logic [14:0] curve_b;
  logic [11:0] alaw_n_b;
  logic [16:0] mulaw_sum_b;
  logic [12:0] mulaw_n_b;
  logic [12:0] law_n_b;
  logic [3:0]  law_pos_b;

  always_comb begin
    neg_b       = sample_a_q[15];
    mag_b       = neg_b ? 16'(~sample_a_q + 16'd1) : sample_a_q;
    even_b      = {mag_b[15:1], 1'b0};
    // only 32768 has bit 15 set: clamp to the curve's top input
    curve_b     = mag_b[15] ? 15'h7FFF : mag_b[14:0];
    alaw_n_b    = (|even_b[15:12]) ? ALAW_LIMIT : even_b[11:0];
    mulaw_sum_b = {1'b0, even_b} + MULAW_OFFSET;
    mulaw_n_b   = (|mulaw_sum_b[16:13]) ? MULAW_LIMIT : mulaw_sum_b[12:0];
    law_n_b     = (mode_a_q == MODE_ALAW) ? {1'b0, alaw_n_b} : mulaw_n_b;

    // top set bit among 5..12, else the floor position
    law_pos_b = LAW_MIN_POS;
    for (int i = 5; i < 13; i++) begin
      if (law_n_b[i]) law_pos_b = 4'(i);
    end

    seg_d.mode = mode_a_q;
    unique case (mode_a_q)
      MODE_CURVE4: begin
        seg_d.sgn = neg_b;
        seg_d.op  = curve_b;
        seg_d.seg = {2'b00, curve_b[14:13]};
      end
      MODE_CURVE8: begin
        seg_d.sgn = neg_b;
        seg_d.op  = curve_b;
        seg_d.seg = {1'b0, curve_b[14:12]};
      end
      default: begin
        // law sign counts only on a nonzero magnitude
        seg_d.sgn = neg_b && (|even_b);
        seg_d.op  = {2'b00, law_n_b};
        seg_d.seg = law_pos_b;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready_b) seg_q <= seg_d;
  end

  // Stage C: curve value or law code
  logic [2:0]  k_c;
  logic [12:0] rem_c;
  logic [16:0] prod_c;
  logic [3:0]  shift_c;
  logic [3:0]  low_c;
  logic [7:0]  code_c;

  always_comb begin
    k_c     = seg_q.seg[2:0];
    rem_c   = (seg_q.mode == MODE_CURVE4) ? seg_q.op[12:0] : {1'b0, seg_q.op[11:0]};
    // first segment slope: 3 (four segments) or 6 (eight segments)
    prod_c  = (seg_q.mode == MODE_CURVE4) ? ({2'b00, seg_q.op} * 17'd3)
                                          : ({2'b00, seg_q.op} * 17'd6);
    shift_c = 4'd0;
    low_c   = 4'd0;
    code_c  = 8'd0;
    val_d.mode = seg_q.mode;
    val_d.sgn  = seg_q.sgn;

    unique case (seg_q.mode) inside
      MODE_CURVE4, MODE_CURVE8: begin
        if (k_c == 3'd0) begin
          val_d.val = prod_c[14:0];
        end else begin
          val_d.val = curve_base(seg_q.mode == MODE_CURVE8, k_c) + 15'(rem_c >> k_c);
        end
      end
      MODE_ALAW: begin
        shift_c   = (seg_q.seg == LAW_MIN_POS) ? 4'd1 : (seg_q.seg - LAW_MIN_POS);
        low_c     = 4'(seg_q.op[12:0] >> shift_c);
        code_c    = {seg_q.sgn, 3'(seg_q.seg - LAW_MIN_POS), low_c} ^ ALAW_XOR;
        val_d.val = {7'd0, code_c};
      end
      default: begin
        // mu-law: the bias keeps the top bit at 5 or above
        shift_c   = seg_q.seg - LAW_MIN_POS;
        low_c     = 4'(seg_q.op[12:0] >> shift_c);
        code_c    = ~{seg_q.sgn, 3'(seg_q.seg - 4'd5), low_c};
        val_d.val = {7'd0, code_c};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready_c) val_q <= val_d;
  end

  // Stage D: sign and output register
  always_comb begin
    unique case (val_q.mode) inside
      MODE_CURVE4, MODE_CURVE8: begin
        coded_d = val_q.sgn ? 16'(-{1'b0, val_q.val}) : {1'b0, val_q.val};
      end
      default: begin
        coded_d = {{8{val_q.val[7]}}, val_q.val[7:0]};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready_d) coded_q <= coded_d;
  end

  assign m_axis_tvalid = valid_d_q;
  assign m_axis_tdata  = coded_q;

  // Assertions
  `ACE_ASSERT_NOW(a_full_when_blocked, !s_axis_tready,
                  valid_a_q && valid_b_q && valid_c_q && valid_d_q,
                  "input blocked with a free stage")
  `ACE_ASSERT_NEXT(a_bubble_closes, valid_c_q && !valid_d_q, valid_d_q,
                   "stage C did not advance into empty output")
  `ACE_ASSERT_NOW(a_law_sign_ext,
                  m_axis_tvalid && (mode_q == MODE_ALAW || mode_q == MODE_MULAW),
                  m_axis_tdata[15:8] == {8{m_axis_tdata[7]}},
                  "law code not sign-extended")

endmodule
